// ===== design/bts_pkg.sv =====
// shared constants and types of the bilinear texture sampler
package bts_pkg;
    localparam int unsigned DEF_MAX_WIDTH  = 128;
    localparam int unsigned DEF_MAX_HEIGHT = 128;
    localparam int unsigned DEF_FRAC_BITS  = 16;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned CFG_DATA_W     = 8;
    localparam int unsigned TEXEL_W        = 24;
    localparam int unsigned INDEX_W        = 14;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

    typedef enum logic {KIND_WRITE = 1'b0, KIND_SAMPLE = 1'b1} kind_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;
endpackage

// ===== design/bts_in_if.sv =====
// input channel: texel writes and sample requests
interface bts_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bts_pkg::INDEX_W-1:0]  texel_index;
    logic [7:0]                   red_in;
    logic [7:0]                   green_in;
    logic [7:0]                   blue_in;
    logic signed [31:0]           u_coord;
    logic signed [31:0]           v_coord;

    modport source (output valid, kind, texel_index, red_in, green_in, blue_in,
                    u_coord, v_coord, input ready);
    modport sink   (input valid, kind, texel_index, red_in, green_in, blue_in,
                    u_coord, v_coord, output ready);
endinterface

// ===== design/bts_out_if.sv =====
// output channel: filtered colors
interface bts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== design/bts_bank.sv =====
// one copy of the texel store: one write port, two registered read ports
module bts_bank #(
    parameter int unsigned DEPTH  = 16384,
    parameter int unsigned ADDR_W = 14
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [bts_pkg::TEXEL_W-1:0]   wdata,
    input  logic                          re,
    input  logic [ADDR_W-1:0]             raddr0,
    input  logic [ADDR_W-1:0]             raddr1,
    output logic [bts_pkg::TEXEL_W-1:0]   rdata0,
    output logic [bts_pkg::TEXEL_W-1:0]   rdata1
);
    import bts_pkg::*;

    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rdata0_reg;
    logic [TEXEL_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;
endmodule

// ===== design/bts_axis.sv =====
// one axis: wraps a coordinate, scales by size-1, gives neighbours and weight
module bts_axis #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned POS_W     = 7
) (
    input  logic [31:0]           coord,
    input  logic [POS_W:0]        size,
    output logic [POS_W-1:0]      i0,
    output logic [POS_W-1:0]      i1,
    output logic [FRAC_BITS-1:0]  frac
);
    import bts_pkg::*;

    logic [FRAC_BITS-1:0]       f;
    logic [FRAC_BITS+POS_W:0]   p;
    logic [POS_W:0]             a;
    logic [POS_W:0]             a1;

    always_comb
    begin
        f    = coord[FRAC_BITS-1:0];
        p    = (FRAC_BITS+POS_W+1)'(f) * (FRAC_BITS+POS_W+1)'(size - 1'b1);
        a    = p[FRAC_BITS+POS_W:FRAC_BITS];
        if (a >= size)
        begin
            a = size - 1'b1;
        end
        a1   = a + 1'b1;
        if (a1 >= size)
        begin
            a1 = '0;
        end
        i0   = a[POS_W-1:0];
        i1   = a1[POS_W-1:0];
        frac = p[FRAC_BITS-1:0];
    end
endmodule

// ===== design/bilinear_texture_sampler_core.sv =====
// top level of the bilinear texture sampler
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | kind, texel_index, rgb in, u/v 16.16
//  out_ch   | out | valid/ready  | rgb out
//  cfg      | in  | cfg_we       | tex_width (0), tex_height (1)
// one item per clock unless stalled; a sample result passes the stage 1, bank read, weight
// and colour, and output registers in order (axis setup, address and read, weights, blend)
// the store is kept in two copies, one per neighbour row, two read ports each; a write
// lands at its own transfer, ahead of any later sample read, so no forwarding is needed
// the whole pipeline stalls while the output register is full and not taken
// reset clears the valid flags and loads 64 into both size registers; texels are undefined until written
module bilinear_texture_sampler_core #(
    parameter int unsigned MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned FRAC_BITS  = bts_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_data,
    bts_in_if.sink                          in_ch,
    bts_out_if.source                       out_ch
);
    import bts_pkg::*;

    localparam int unsigned XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned MW    = XW + YW + 1;
    localparam int unsigned FW    = FRAC_BITS + 1;
    localparam int unsigned PW    = 2 * FW;
    localparam int unsigned SW    = 2 * FRAC_BITS + 10;

    // ---------------- configuration
    logic [7:0] tex_width_reg, tex_height_reg;
    logic [XW:0] w_eff;
    logic [YW:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 8'd64;
            tex_height_reg <= 8'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (tex_width_reg == 8'd0)
            w_eff = (XW+1)'(1);
        else if (32'(tex_width_reg) > MAX_WIDTH)
            w_eff = (XW+1)'(MAX_WIDTH);
        else
            w_eff = (XW+1)'(tex_width_reg);
        if (tex_height_reg == 8'd0)
            h_eff = (YW+1)'(1);
        else if (32'(tex_height_reg) > MAX_HEIGHT)
            h_eff = (YW+1)'(MAX_HEIGHT);
        else
            h_eff = (YW+1)'(tex_height_reg);
    end

    // ---------------- pipeline control
    logic adv;
    logic out_valid_reg;
    logic v1_reg, v2_reg, v3_reg;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    logic in_xfer;
    assign in_xfer = in_ch.valid && adv;

    // ---------------- stage 0: texel write, sample axis setup
    logic [INDEX_W-1:0] widx;
    logic               wr_ok;
    logic [AW-1:0]      waddr;
    logic [TEXEL_W-1:0] wdata;

    assign widx  = in_ch.texel_index;
    assign wr_ok = in_xfer && (in_ch.kind == KIND_WRITE) && (32'(widx) < DEPTH);
    assign waddr = AW'(widx);
    assign wdata = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};

    // sample axes
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;

    bts_axis #(.FRAC_BITS(FRAC_BITS), .POS_W(XW)) u_ax (
        .coord(in_ch.u_coord), .size(w_eff), .i0(x0), .i1(x1), .frac(fx));
    bts_axis #(.FRAC_BITS(FRAC_BITS), .POS_W(YW)) u_ay (
        .coord(in_ch.v_coord), .size(h_eff), .i0(y0), .i1(y1), .frac(fy));

    // stage 1 registers: neighbour coordinates and weights
    logic [XW-1:0] x0_reg, x1_reg;
    logic [YW-1:0] y0_reg, y1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= in_ch.valid && (in_ch.kind == KIND_SAMPLE);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= x0; x1_reg <= x1; y0_reg <= y0; y1_reg <= y1;
            fx_reg <= fx; fy_reg <= fy;
        end
    end

    // ---------------- texel addresses: row-major y*width+x
    logic [MW-1:0] row0, row1;
    logic [AW-1:0] raddr [4];

    always_comb
    begin
        row0     = MW'(y0_reg) * MW'(w_eff);
        row1     = MW'(y1_reg) * MW'(w_eff);
        raddr[0] = AW'(row0 + MW'(x0_reg));
        raddr[1] = AW'(row0 + MW'(x1_reg));
        raddr[2] = AW'(row1 + MW'(x0_reg));
        raddr[3] = AW'(row1 + MW'(x1_reg));
    end

    logic [TEXEL_W-1:0] rd00, rd01, rd10, rd11;

    bts_bank #(.DEPTH(DEPTH), .ADDR_W(AW)) u_bank_row0 (
        .clk(clk), .we(wr_ok), .waddr(waddr), .wdata(wdata), .re(adv),
        .raddr0(raddr[0]), .raddr1(raddr[1]), .rdata0(rd00), .rdata1(rd01));

    bts_bank #(.DEPTH(DEPTH), .ADDR_W(AW)) u_bank_row1 (
        .clk(clk), .we(wr_ok), .waddr(waddr), .wdata(wdata), .re(adv),
        .raddr0(raddr[2]), .raddr1(raddr[3]), .rdata0(rd10), .rdata1(rd11));

    // stage 2: data returns, weights multiply
    logic [FRAC_BITS-1:0] fx2_reg, fy2_reg;
    logic [PW-1:0] wt_reg [4];
    logic [PW-1:0] wt_next [4];
    logic [FW-1:0] ax0, ax1, ay0, ay1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx2_reg <= fx_reg; fy2_reg <= fy_reg;
        end
    end

    logic [TEXEL_W-1:0] c [4];
    logic [TEXEL_W-1:0] c_reg [4];

    always_comb
    begin
        ax1 = FW'(fx2_reg);
        ax0 = FW'(1) << FRAC_BITS;
        ax0 = ax0 - ax1;
        ay1 = FW'(fy2_reg);
        ay0 = (FW'(1) << FRAC_BITS) - ay1;
        wt_next[0] = PW'(ax0) * PW'(ay0);
        wt_next[1] = PW'(ax1) * PW'(ay0);
        wt_next[2] = PW'(ax0) * PW'(ay1);
        wt_next[3] = PW'(ax1) * PW'(ay1);
        c[0] = rd00;
        c[1] = rd01;
        c[2] = rd10;
        c[3] = rd11;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                wt_reg[k] <= wt_next[k];
                c_reg[k]  <= c[k];
            end
        end
    end

    // stage 3: blend into the output register
    rgb_t blend;
    logic [SW-1:0] acc [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            acc[ch] = '0;
            for (int k = 0; k < 4; k++)
                acc[ch] = acc[ch] + SW'(c_reg[k][16-8*ch +: 8]) * SW'(wt_reg[k]);
        end
        blend.red   = acc[0][2*FRAC_BITS +: 8];
        blend.green = acc[1][2*FRAC_BITS +: 8];
        blend.blue  = acc[2][2*FRAC_BITS +: 8];
    end

    rgb_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= blend;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.red_out   = out_reg.red;
    assign out_ch.green_out = out_reg.green;
    assign out_ch.blue_out  = out_reg.blue;
endmodule
